[hw/rtl/nibble_complement_frame_receiver_core_assert.svh]
// Assertion macros for the nibble-complement frame receiver.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef NIBBLE_COMPLEMENT_FRAME_RECEIVER_CORE_ASSERT_SVH
`define NIBBLE_COMPLEMENT_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTH
// Check a property outside reset.
`define NCFR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ncfr assertion failed");
// Check a property at every edge, reset included.
`define NCFR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ncfr assertion failed");
`else
`define NCFR_ASSERT(label, prop)
`define NCFR_ASSERT_ALWAYS(label, prop)
`endif

`endif

[hw/rtl/ncfr_pkg.sv]
// Package for the nibble-complement frame receiver: frame marks,
// frame end codes and field widths. No dependencies.
package ncfr_pkg;

    localparam logic [7:0] START_CHAR     = 8'h53;  // 'S'
    localparam logic [7:0] CLOSE_CHAR     = 8'h43;  // 'C'
    localparam logic [3:0] START_LOW      = 4'h5;
    localparam logic [3:0] CLOSE_HIGH     = 4'h3;
    localparam logic [3:0] NIBBLE_ALL     = 4'hF;
    localparam logic [7:0] FRAME_LEN_RST  = 8'd32;
    localparam logic [7:0] POSITION_RST   = 8'd1;
    localparam logic [7:0] FIRST_DATA_POS = 8'd3;

    typedef enum logic [1:0] {
        FE_NONE     = 2'd0,
        FE_CLOSE    = 2'd1,
        FE_LIMIT    = 2'd2,
        FE_LINE_ERR = 2'd3
    } frame_end_t;

    typedef logic [7:0] byte_t;

endpackage

[hw/rtl/ncfr_if.sv]
// Channel interfaces of the nibble-complement frame receiver:
// received bytes, decoded results and the frame length write. Uses ncfr_pkg.

interface ncfr_rx_if;
    import ncfr_pkg::*;
    logic  valid;
    logic  ready;
    byte_t rx_byte;
    logic  line_error;
    modport source (output valid, output rx_byte, output line_error, input ready);
    modport sink (input valid, input rx_byte, input line_error, output ready);
endinterface

interface ncfr_res_if;
    import ncfr_pkg::*;
    logic       valid;
    logic       ready;
    logic       data_valid;
    byte_t      data_byte;
    logic       upper_check_error;
    logic       lower_check_error;
    frame_end_t frame_end;
    modport source (output valid, output data_valid, output data_byte,
                    output upper_check_error, output lower_check_error,
                    output frame_end, input ready);
    modport sink (input valid, input data_valid, input data_byte,
                  input upper_check_error, input lower_check_error,
                  input frame_end, output ready);
endinterface

interface ncfr_cfg_if;
    import ncfr_pkg::*;
    logic  valid;
    logic  ready;
    byte_t frame_length;
    modport source (output valid, output frame_length, input ready);
    modport sink (input valid, input frame_length, output ready);
endinterface

[hw/rtl/nibble_complement_frame_receiver_core.sv]
// Nibble-complement frame receiver core: frame detection and payload decode.
// Depends on ncfr_pkg, the interfaces in ncfr_if.sv and the assertion header.
//
//  channel | modport | payload                                   | role
//  --------+---------+-------------------------------------------+--------------------------
//  rx      | sink    | rx_byte, line_error                       | serial bytes in
//  res     | source  | data_valid, data_byte, upper/lower check  | decoded byte, frame end
//          |         | errors, frame_end                         |
//  cfg     | sink    | frame_length                              | frame length register
//
// Two register stages: an input register takes each transaction, and the frame logic runs on
// it and loads the result register when the input stage advances. One byte per cycle
// sustained while res is taken; res.valid rises when a result enters the result register.
// The input register advances whenever the result register is empty or being taken,
// so a stalled res holds at most the one byte in the input register.
// Reset clears the frame state, the position to 1 and frame_length to 32; cfg is
// always ready and must be written only while the block is idle.
`include "nibble_complement_frame_receiver_core_assert.svh"

module nibble_complement_frame_receiver_core
(
    input logic   clk,
    input logic   rst_n,
    ncfr_rx_if.sink    rx,
    ncfr_res_if.source res,
    ncfr_cfg_if.sink   cfg
);
    import ncfr_pkg::*;

    // Input register stage
    logic  in_valid_reg;
    byte_t in_byte_reg;
    logic  in_err_reg;
    logic  in_adv;

    // Frame state
    logic  saw_start_reg, saw_start_next;
    logic  in_frame_reg, in_frame_next;
    byte_t position_reg, position_next;
    byte_t last_reg, last_next;
    byte_t before_last_reg, before_last_next;
    byte_t frame_len_reg;

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic       dv_reg, dv_next;
    byte_t      db_reg, db_next;
    logic       ue_reg, ue_next;
    logic       le_reg, le_next;
    frame_end_t fe_reg, fe_next;
    logic       produce;

    byte_t pos_inc;
    byte_t limit;
    logic  closing;
    logic  empty_result_ok;

    // Advance the input stage when the result register can take a result.
    assign in_adv   = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || in_adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
            in_err_reg  <= rx.line_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= FRAME_LEN_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            frame_len_reg <= cfg.frame_length;
        end
    end

    assign pos_inc = position_reg + 8'd1;
    assign limit   = frame_len_reg - 8'd1;
    assign closing = (in_byte_reg == CLOSE_CHAR) && (last_reg[7:4] == CLOSE_HIGH);

    // Frame logic: one byte from the input register into the result register.
    always_comb
    begin
        saw_start_next   = saw_start_reg;
        in_frame_next    = in_frame_reg;
        position_next    = position_reg;
        last_next        = last_reg;
        before_last_next = before_last_reg;
        dv_next          = 1'b0;
        db_next          = '0;
        ue_next          = 1'b0;
        le_next          = 1'b0;
        fe_next          = FE_NONE;
        produce          = 1'b0;

        if (in_err_reg)
        begin
            // Drop the byte, keep the history, close any frame.
            saw_start_next = 1'b0;
            in_frame_next  = 1'b0;
            position_next  = POSITION_RST;
            fe_next        = FE_LINE_ERR;
            produce        = 1'b1;
        end
        else if (!in_frame_reg)
        begin
            if (saw_start_reg)
            begin
                if (in_byte_reg[3:0] == START_LOW)
                begin
                    in_frame_next = 1'b1;
                    position_next = POSITION_RST;
                end
                saw_start_next = 1'b0;
            end
            else if (in_byte_reg == START_CHAR)
            begin
                saw_start_next = 1'b1;
            end
            before_last_next = last_reg;
            last_next        = in_byte_reg;
        end
        else
        begin
            position_next = pos_inc;
            // Odd position from the third on closes a pair: decode it.
            if (pos_inc[0] && (pos_inc >= FIRST_DATA_POS))
            begin
                dv_next = 1'b1;
                db_next = {before_last_reg[7:4], last_reg[7:4]};
                ue_next = ((before_last_reg[7:4] | last_reg[3:0]) != NIBBLE_ALL);
                le_next = ((last_reg[7:4] | in_byte_reg[3:0]) != NIBBLE_ALL);
            end
            if (closing)
            begin
                position_next = POSITION_RST;
                in_frame_next = 1'b0;
                fe_next       = FE_CLOSE;
            end
            else if (pos_inc == limit)
            begin
                position_next = POSITION_RST;
                in_frame_next = 1'b0;
                fe_next       = FE_LIMIT;
            end
            before_last_next = last_reg;
            last_next        = in_byte_reg;
            produce          = dv_next || (fe_next != FE_NONE);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !res.ready;
        if (in_adv && produce)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saw_start_reg   <= 1'b0;
            in_frame_reg    <= 1'b0;
            position_reg    <= POSITION_RST;
            last_reg        <= '0;
            before_last_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_adv)
            begin
                saw_start_reg   <= saw_start_next;
                in_frame_reg    <= in_frame_next;
                position_reg    <= position_next;
                last_reg        <= last_next;
                before_last_reg <= before_last_next;
            end
        end
    end

    // Hold the result payload until a new result replaces it.
    always_ff @(posedge clk)
    begin
        if (in_adv && produce)
        begin
            dv_reg <= dv_next;
            db_reg <= db_next;
            ue_reg <= ue_next;
            le_reg <= le_next;
            fe_reg <= fe_next;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.data_valid        = dv_reg;
    assign res.data_byte         = db_reg;
    assign res.upper_check_error = ue_reg;
    assign res.lower_check_error = le_reg;
    assign res.frame_end         = fe_reg;

    // A result without data must carry a frame end and zeroed data fields.
    assign empty_result_ok = (fe_reg != FE_NONE) && (db_reg == 8'd0) && !ue_reg && !le_reg;

    `NCFR_ASSERT_ALWAYS(a_start_xor_frame, !(saw_start_reg && in_frame_reg))
    `NCFR_ASSERT(a_frame_opens_at_one, $rose(in_frame_reg) |-> (position_reg == POSITION_RST))
    `NCFR_ASSERT(a_result_from_input, $rose(out_valid_reg) |-> $past(in_valid_reg))
    `NCFR_ASSERT(a_empty_result_ends_frame, (out_valid_reg && !dv_reg) |-> empty_result_ok)
    `NCFR_ASSERT(a_line_error_no_data, (out_valid_reg && fe_reg == FE_LINE_ERR) |-> !dv_reg)

endmodule
